// ===== src/b2u_pkg.sv =====
// Shared types, weights and helper functions for the BGRA to 4:2:2 fill/key converter.
`default_nettype none

package b2u_pkg;

  // Input transfer: one pair of adjacent BGRA pixels plus line and frame marks.
  typedef struct packed {
    logic [7:0] blue_first;
    logic [7:0] green_first;
    logic [7:0] red_first;
    logic [7:0] alpha_first;
    logic [7:0] blue_second;
    logic [7:0] green_second;
    logic [7:0] red_second;
    logic [7:0] alpha_second;
    logic       line_end;
    logic       frame_end;
  } in_t;

  // Output transfer: one 4:2:2 fill word, the key luma pair and the marks.
  typedef struct packed {
    logic [7:0] cb_avg;
    logic [7:0] luma_first;
    logic [7:0] cr_avg;
    logic [7:0] luma_second;
    logic [7:0] key_luma_first;
    logic [7:0] key_luma_second;
    logic       line_end_out;
    logic       frame_end_out;
  } out_t;

  // Stage 1 result: biased weighted sums (the output byte sits in bits 15:8)
  // and the key numerators.
  typedef struct packed {
    logic [15:0] luma_first_sum;
    logic [15:0] luma_second_sum;
    logic [15:0] cb_first_sum;
    logic [15:0] cb_second_sum;
    logic [15:0] cr_first_sum;
    logic [15:0] cr_second_sum;
    logic [15:0] key_first_num;
    logic [15:0] key_second_num;
    logic        line_end;
    logic        frame_end;
  } s1_t;

  // Stage 2 result: luma bytes, chroma pair sums, and key quotient estimates
  // with their remainders.
  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] luma_second;
    logic [8:0] cb_sum;
    logic [8:0] cr_sum;
    logic [7:0] key_first_quo;
    logic [8:0] key_first_rem;
    logic [7:0] key_second_quo;
    logic [8:0] key_second_rem;
    logic       line_end;
    logic       frame_end;
  } s2_t;

  // Color weights, signed, wide enough for 8-bit products and the bias.
  localparam logic signed [18:0] Y_R  = 19'sd47;
  localparam logic signed [18:0] Y_G  = 19'sd157;
  localparam logic signed [18:0] Y_B  = 19'sd16;
  localparam logic signed [18:0] CB_R = -19'sd26;
  localparam logic signed [18:0] CB_G = -19'sd87;
  localparam logic signed [18:0] CB_B = 19'sd112;
  localparam logic signed [18:0] CR_R = 19'sd112;
  localparam logic signed [18:0] CR_G = -19'sd102;
  localparam logic signed [18:0] CR_B = -19'sd10;

  // Rounding half plus the output offset scaled by 256.
  localparam logic signed [18:0] Y_BIAS = 19'sd128 + 19'sd16 * 19'sd256;
  localparam logic signed [18:0] C_BIAS = 19'sd128 + 19'sd128 * 19'sd256;

  // Key luma: 16 + floor((a * 219 + 127) / 255).
  localparam logic [15:0] KEY_GAIN   = 16'd219;
  localparam logic [15:0] KEY_ROUND  = 16'd127;
  localparam logic [8:0]  KEY_DIV    = 9'd255;
  localparam logic [7:0]  KEY_OFFSET = 8'd16;

  // Weighted sum of one pixel plus bias. The bias keeps the value positive
  // for every input, so bits 15:8 are the floored, offset result.
  function automatic logic [15:0] weigh3(
    input logic [7:0]        r,
    input logic [7:0]        g,
    input logic [7:0]        b,
    input logic signed [18:0] kr,
    input logic signed [18:0] kg,
    input logic signed [18:0] kb,
    input logic signed [18:0] bias
  );
    logic signed [18:0] acc;
    acc = kr * $signed({11'd0, r}) + kg * $signed({11'd0, g})
        + kb * $signed({11'd0, b}) + bias;
    return acc[15:0];
  endfunction

  // Key numerator a * 219 + 127, at most 55972.
  function automatic logic [15:0] key_num(input logic [7:0] a);
    return {8'd0, a} * KEY_GAIN + KEY_ROUND;
  endfunction

endpackage

`default_nettype wire

// ===== src/b2u_weigh.sv =====
// Stage 1: per-pixel weighted color sums and key numerators.
`default_nettype none

module b2u_weigh (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           up_valid,
  input  wire b2u_pkg::in_t   up_data,
  output logic                up_ready,
  output logic                dn_valid,
  output b2u_pkg::s1_t        dn_data,
  input  wire logic           dn_ready
);

  logic         valid_r;
  b2u_pkg::s1_t data_r;
  b2u_pkg::s1_t data_nxt;

  // The stage takes a new transfer when empty or when its content moves on.
  assign up_ready = !valid_r || dn_ready;

  // Weighted sums for both pixels; constant weights reduce to shift-adds.
  always_comb begin
    data_nxt.luma_first_sum  = b2u_pkg::weigh3(up_data.red_first, up_data.green_first,
      up_data.blue_first, b2u_pkg::Y_R, b2u_pkg::Y_G, b2u_pkg::Y_B, b2u_pkg::Y_BIAS);
    data_nxt.luma_second_sum = b2u_pkg::weigh3(up_data.red_second, up_data.green_second,
      up_data.blue_second, b2u_pkg::Y_R, b2u_pkg::Y_G, b2u_pkg::Y_B, b2u_pkg::Y_BIAS);
    data_nxt.cb_first_sum    = b2u_pkg::weigh3(up_data.red_first, up_data.green_first,
      up_data.blue_first, b2u_pkg::CB_R, b2u_pkg::CB_G, b2u_pkg::CB_B, b2u_pkg::C_BIAS);
    data_nxt.cb_second_sum   = b2u_pkg::weigh3(up_data.red_second, up_data.green_second,
      up_data.blue_second, b2u_pkg::CB_R, b2u_pkg::CB_G, b2u_pkg::CB_B, b2u_pkg::C_BIAS);
    data_nxt.cr_first_sum    = b2u_pkg::weigh3(up_data.red_first, up_data.green_first,
      up_data.blue_first, b2u_pkg::CR_R, b2u_pkg::CR_G, b2u_pkg::CR_B, b2u_pkg::C_BIAS);
    data_nxt.cr_second_sum   = b2u_pkg::weigh3(up_data.red_second, up_data.green_second,
      up_data.blue_second, b2u_pkg::CR_R, b2u_pkg::CR_G, b2u_pkg::CR_B, b2u_pkg::C_BIAS);
    data_nxt.key_first_num   = b2u_pkg::key_num(up_data.alpha_first);
    data_nxt.key_second_num  = b2u_pkg::key_num(up_data.alpha_second);
    data_nxt.line_end        = up_data.line_end;
    data_nxt.frame_end       = up_data.frame_end;
  end

  // Valid bit resets; the payload loads only on a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== src/b2u_merge.sv =====
// Stage 2: luma bytes, chroma pair sums and key division first step.
`default_nettype none

module b2u_merge (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           up_valid,
  input  wire b2u_pkg::s1_t   up_data,
  output logic                up_ready,
  output logic                dn_valid,
  output b2u_pkg::s2_t        dn_data,
  input  wire logic           dn_ready
);

  logic         valid_r;
  b2u_pkg::s2_t data_r;
  b2u_pkg::s2_t data_nxt;

  assign up_ready = !valid_r || dn_ready;

  // Dividing by 255: the quotient estimate is x >> 8, and the remainder
  // (x & 255) + (x >> 8) stays below twice the divisor.
  always_comb begin
    data_nxt.luma_first     = up_data.luma_first_sum[15:8];
    data_nxt.luma_second    = up_data.luma_second_sum[15:8];
    data_nxt.cb_sum         = {1'b0, up_data.cb_first_sum[15:8]}
                            + {1'b0, up_data.cb_second_sum[15:8]};
    data_nxt.cr_sum         = {1'b0, up_data.cr_first_sum[15:8]}
                            + {1'b0, up_data.cr_second_sum[15:8]};
    data_nxt.key_first_quo  = up_data.key_first_num[15:8];
    data_nxt.key_first_rem  = {1'b0, up_data.key_first_num[7:0]}
                            + {1'b0, up_data.key_first_num[15:8]};
    data_nxt.key_second_quo = up_data.key_second_num[15:8];
    data_nxt.key_second_rem = {1'b0, up_data.key_second_num[7:0]}
                            + {1'b0, up_data.key_second_num[15:8]};
    data_nxt.line_end       = up_data.line_end;
    data_nxt.frame_end      = up_data.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== src/b2u_finish.sv =====
// Stage 3: chroma averaging, key quotient correction and the output register.
`default_nettype none

module b2u_finish (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           up_valid,
  input  wire b2u_pkg::s2_t   up_data,
  output logic                up_ready,
  output logic                dn_valid,
  output b2u_pkg::out_t       dn_data,
  input  wire logic           dn_ready
);

  logic          valid_r;
  b2u_pkg::out_t data_r;
  b2u_pkg::out_t data_nxt;
  logic [7:0]    key_first_quo;
  logic [7:0]    key_second_quo;

  assign up_ready = !valid_r || dn_ready;

  // Add one to the quotient estimate when the remainder reaches the divisor.
  assign key_first_quo  = up_data.key_first_quo
                        + {7'd0, (up_data.key_first_rem >= b2u_pkg::KEY_DIV)};
  assign key_second_quo = up_data.key_second_quo
                        + {7'd0, (up_data.key_second_rem >= b2u_pkg::KEY_DIV)};

  // Truncating average of the pair; a 9-bit sum halved always fits a byte.
  always_comb begin
    data_nxt.cb_avg          = up_data.cb_sum[8:1];
    data_nxt.luma_first      = up_data.luma_first;
    data_nxt.cr_avg          = up_data.cr_sum[8:1];
    data_nxt.luma_second     = up_data.luma_second;
    data_nxt.key_luma_first  = key_first_quo + b2u_pkg::KEY_OFFSET;
    data_nxt.key_luma_second = key_second_quo + b2u_pkg::KEY_OFFSET;
    data_nxt.line_end_out    = up_data.line_end;
    data_nxt.frame_end_out   = up_data.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== src/bgra_to_uyvy_fill_key_core.sv =====
// Top level of the BGRA pixel pair to 4:2:2 fill and key converter.
//
//   Channel  Direction  Ports                          Moves
//   in       input      in_valid, in_stall, in_data    one BGRA pixel pair and marks
//   out      output     out_valid, out_stall, out_data one fill word, key luma, marks
//
// One pixel pair per cycle is taken while in_stall is low; each result passes
// through one register per stage (weighting, merge, finish).
// Reset clears only the three stage valid bits; the pipeline is then empty.
// A stall on the output holds the last stage; earlier stages keep filling any
// empty slot, so in_stall rises only when all three stages hold data.
`default_nettype none

module bgra_to_uyvy_fill_key_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire b2u_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output b2u_pkg::out_t       out_data
);

  logic         s1_ready;
  logic         s1_valid;
  b2u_pkg::s1_t s1_data;
  logic         s2_ready;
  logic         s2_valid;
  b2u_pkg::s2_t s2_data;
  logic         s3_ready;

  assign in_stall = !s1_ready;

  // Stage 1: color weighting.
  b2u_weigh u_weigh (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_data  (in_data),
    .up_ready (s1_ready),
    .dn_valid (s1_valid),
    .dn_data  (s1_data),
    .dn_ready (s2_ready)
  );

  // Stage 2: byte extraction and pair sums.
  b2u_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_data  (s1_data),
    .up_ready (s2_ready),
    .dn_valid (s2_valid),
    .dn_data  (s2_data),
    .dn_ready (s3_ready)
  );

  // Stage 3: averaging, key correction, output register.
  b2u_finish u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_data  (s2_data),
    .up_ready (s3_ready),
    .dn_valid (out_valid),
    .dn_data  (out_data),
    .dn_ready (!out_stall)
  );

endmodule

`default_nettype wire

// ===== test/bgra_to_uyvy_fill_key_core_tb.sv =====
// Self-checking testbench for the BGRA pixel pair to 4:2:2 fill and key converter.
`default_nettype none

module bgra_to_uyvy_fill_key_core_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PAIRS = 450;
  localparam int REPORT_CAP   = 100;
  // No idling on either side while the cycle count is in this window.
  localparam int QUIET_FROM   = 300;
  localparam int QUIET_TO     = 550;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  b2u_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  b2u_pkg::out_t out_data;

  b2u_pkg::in_t  pixel_pairs[$];
  b2u_pkg::out_t fill_key_expected[$];
  int   cycle_count = 0;
  int   pairs_taken = 0;
  int   pair_total = 0;
  int   words_seen = 0;
  int   mismatches = 0;
  logic pair_taken = 1'b0;

  bgra_to_uyvy_fill_key_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Weighted sum with rounding and offset, floored by a shift of 8.
  function automatic int scaled_sum(int s, int offset);
    int biased;
    biased = s + 128 + offset * 256;
    if (biased < 0) begin
      biased = 0;
    end
    return biased >> 8;
  endfunction

  function automatic logic [7:0] sat_byte(int v);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [7:0] key_luma(logic [7:0] a);
    int k;
    k = 16 + (int'(a) * 219 + 127) / 255;
    return k[7:0];
  endfunction

  // Expected fill word, key luma and marks for one pixel pair.
  function automatic b2u_pkg::out_t convert_pair(b2u_pkg::in_t px);
    b2u_pkg::out_t w;
    int r0, g0, b0, r1, g1, b1;
    int cb, cr;
    r0 = px.red_first;
    g0 = px.green_first;
    b0 = px.blue_first;
    r1 = px.red_second;
    g1 = px.green_second;
    b1 = px.blue_second;
    cb = (scaled_sum(-26 * r0 - 87 * g0 + 112 * b0, 128)
        + scaled_sum(-26 * r1 - 87 * g1 + 112 * b1, 128)) / 2;
    cr = (scaled_sum(112 * r0 - 102 * g0 - 10 * b0, 128)
        + scaled_sum(112 * r1 - 102 * g1 - 10 * b1, 128)) / 2;
    w.cb_avg          = sat_byte(cb);
    w.luma_first      = sat_byte(scaled_sum(47 * r0 + 157 * g0 + 16 * b0, 16));
    w.cr_avg          = sat_byte(cr);
    w.luma_second     = sat_byte(scaled_sum(47 * r1 + 157 * g1 + 16 * b1, 16));
    w.key_luma_first  = key_luma(px.alpha_first);
    w.key_luma_second = key_luma(px.alpha_second);
    w.line_end_out    = px.line_end;
    w.frame_end_out   = px.frame_end;
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_CAP) begin
      $display("mismatch at result %0d: %s", words_seen, what);
    end
  endtask

  task automatic check_byte(input string field, input logic [7:0] got,
                            input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
    end
  endtask

  task automatic add_pair(input logic [7:0] b0, g0, r0, a0, b1, g1, r1, a1,
                          input logic le, fe);
    b2u_pkg::in_t px;
    px = '{b0, g0, r0, a0, b1, g1, r1, a1, le, fe};
    pixel_pairs.push_back(px);
  endtask

  // Mostly random bytes, with the two extremes often enough to matter.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic quiet_window();
    return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
  endfunction

  // Cycle counter with the overall timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Driver: offers the next pixel pair once the current one has been transferred.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || pair_taken) begin
        if (pixel_pairs.size() == 0 || (!quiet_window() && $urandom_range(0, 99) < 20)) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= pixel_pairs.pop_front();
        end
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    out_stall <= !quiet_window() && ($urandom_range(0, 99) < 20);
  end

  // Monitor: predicts each input transfer and checks each output transfer.
  always @(posedge clk) begin
    b2u_pkg::out_t want;
    pair_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        fill_key_expected.push_back(convert_pair(in_data));
        pairs_taken++;
      end
      if (out_valid && !out_stall) begin
        words_seen++;
        if (fill_key_expected.size() == 0) begin
          report_mismatch("result with no pixel pair pending");
        end else begin
          want = fill_key_expected.pop_front();
          check_byte("cb_avg", out_data.cb_avg, want.cb_avg);
          check_byte("luma_first", out_data.luma_first, want.luma_first);
          check_byte("cr_avg", out_data.cr_avg, want.cr_avg);
          check_byte("luma_second", out_data.luma_second, want.luma_second);
          check_byte("key_luma_first", out_data.key_luma_first, want.key_luma_first);
          check_byte("key_luma_second", out_data.key_luma_second,
                     want.key_luma_second);
          check_byte("line_end_out", 8'(out_data.line_end_out), 8'(want.line_end_out));
          check_byte("frame_end_out", 8'(out_data.frame_end_out), 8'(want.frame_end_out));
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    // Black and white, transparent and opaque, marks in every combination.
    add_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    add_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
    add_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 1'b0, 1'b1);
    add_pair(8'd255, 8'd255, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0, 8'd254, 1'b1, 1'b1);
    // Pure primaries on each pixel.
    add_pair(8'd0, 8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd0, 8'd127, 1'b0, 1'b0);
    add_pair(8'd255, 8'd0, 8'd0, 8'd64, 8'd0, 8'd0, 8'd255, 8'd192, 1'b0, 1'b0);
    add_pair(8'd0, 8'd255, 8'd0, 8'd2, 8'd255, 8'd0, 8'd0, 8'd253, 1'b0, 1'b0);
    // Most negative weighted chroma sums: yellow gives the lowest Cb,
    // cyan the lowest Cr, on both pixels at once.
    add_pair(8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
    add_pair(8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 1'b0, 1'b0);
    // Highest chroma: blue and magenta, red and magenta.
    add_pair(8'd255, 8'd0, 8'd0, 8'd100, 8'd255, 8'd0, 8'd255, 8'd200, 1'b0, 1'b0);
    add_pair(8'd0, 8'd0, 8'd255, 8'd50, 8'd255, 8'd0, 8'd255, 8'd150, 1'b0, 1'b0);
    // Odd chroma pair sums, where the average truncates.
    add_pair(8'd1, 8'd2, 8'd3, 8'd3, 8'd254, 8'd253, 8'd252, 8'd252, 1'b1, 1'b0);
    add_pair(8'd170, 8'd85, 8'd170, 8'd85, 8'd85, 8'd170, 8'd85, 8'd170, 1'b0, 1'b0);
    add_pair(8'd85, 8'd170, 8'd85, 8'd170, 8'd170, 8'd85, 8'd170, 8'd85, 1'b0, 1'b1);

    // Random pairs; line and frame marks come at a realistic rate.
    repeat (RANDOM_PAIRS) begin
      add_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
               pick_byte(), pick_byte(), pick_byte(), pick_byte(),
               $urandom_range(0, 7) == 0, $urandom_range(0, 31) == 0);
    end
    pair_total = pixel_pairs.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pairs_taken != pair_total) @(posedge clk);
    while (fill_key_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && fill_key_expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
